### hdl/prqs_pkg.sv
// Package for the priority ready-queue scheduler.
// Holds field widths, the request and response types and the command codes.
// No dependencies; every other file of the block but prqs_prio_enc imports it.
`default_nettype none

package prqs_pkg;

  localparam int TASK_W = 5;
  localparam int PRIO_W = 4;

  localparam logic [TASK_W-1:0] IDLE_RESET = '0;

  typedef enum logic {
    CMD_MAKE_READY = 1'b0,
    CMD_SWITCH     = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
    logic              requeue_current;
  } req_t;

  typedef struct packed {
    logic [TASK_W-1:0] picked_task;
    logic [PRIO_W-1:0] picked_prio;
    logic              idle_chosen;
    logic              preempt;
    logic              status;
  } rsp_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

endpackage

`default_nettype wire

### hdl/prqs_if.sv
// Channel interfaces of the scheduler: request input, response output and
// the configuration write channel. Depends on prqs_pkg for field widths.
`default_nettype none

interface prqs_in_if import prqs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              command;
  logic [TASK_W-1:0] task_id;
  logic [PRIO_W-1:0] prio;
  logic              requeue_current;

  modport source (output valid, command, task_id, prio, requeue_current, input ready);
  modport sink (input valid, command, task_id, prio, requeue_current, output ready);
endinterface

interface prqs_out_if import prqs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] picked_task;
  logic [PRIO_W-1:0] picked_prio;
  logic              idle_chosen;
  logic              preempt;
  logic              status;

  modport source (output valid, picked_task, picked_prio, idle_chosen, preempt, status,
                  input ready);
  modport sink (input valid, picked_task, picked_prio, idle_chosen, preempt, status,
                output ready);
endinterface

interface prqs_cfg_if import prqs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] idle_task;

  modport source (output valid, idle_task, input ready);
  modport sink (input valid, idle_task, output ready);
endinterface

`default_nettype wire

### hdl/priority_ready_queue_scheduler_unit.sv
// Priority ready-queue scheduler, top level.
// Request channel in_chan carries make-ready and switch requests, out_chan
// returns exactly one response per request in order, and cfg_chan writes the
// idle task id. cfg_chan is always ready and is to be written only while
// idle; the block itself does not enforce this. A request is registered
// into s1_req_r at acceptance; the queue logic resolves it in one pass and
// the response is registered into out_rsp_r, where it holds until taken.
// One request per cycle is sustained while out_chan does not stall.
// The rate is set by the one-pass update of the head, tail and link
// registers plus the priority encode of the active-level bitmap.
// When out_chan stalls, the response holds, the registered request waits,
// and in_chan drops ready once both stages are full.
// Reset (rst_n, synchronous) empties all queues, clears every ready mark,
// makes task 0 current at priority 0 and sets the idle task to 0.
// Depends on prqs_pkg, prqs_if and prqs_ready_queues.
`default_nettype none

module priority_ready_queue_scheduler_unit import prqs_pkg::*; #(
  parameter int PRIO_LEVELS = 16,
  parameter int MAX_TASKS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  prqs_in_if.sink     in_chan,
  prqs_out_if.source  out_chan,
  prqs_cfg_if.sink    cfg_chan
);

  logic              s1_valid_r;
  req_t              s1_req_r;
  logic              out_valid_r;
  rsp_t              out_rsp_r;
  logic [TASK_W-1:0] idle_task_r;
  logic              advance;
  rsp_t              rsp;

  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      idle_task_r <= IDLE_RESET;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_chan.valid) begin
        idle_task_r <= cfg_chan.idle_task;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_req_r.command         <= cmd_t'(in_chan.command);
      s1_req_r.task_id         <= in_chan.task_id;
      s1_req_r.prio            <= in_chan.prio;
      s1_req_r.requeue_current <= in_chan.requeue_current;
    end
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

  prqs_ready_queues #(
    .PRIO_LEVELS (PRIO_LEVELS),
    .MAX_TASKS   (MAX_TASKS)
  ) u_queues (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .req       (s1_req_r),
    .idle_task (idle_task_r),
    .rsp       (rsp)
  );

  assign out_chan.valid       = out_valid_r;
  assign out_chan.picked_task = out_rsp_r.picked_task;
  assign out_chan.picked_prio = out_rsp_r.picked_prio;
  assign out_chan.idle_chosen = out_rsp_r.idle_chosen;
  assign out_chan.preempt     = out_rsp_r.preempt;
  assign out_chan.status      = out_rsp_r.status;

endmodule

`default_nettype wire

### hdl/prqs_prio_enc.sv
// Highest-set-bit encoder over the active-level bitmap.
// Standalone; used by prqs_ready_queues to find the level to dequeue.
`default_nettype none

module prqs_prio_enc #(
  parameter int LEVELS = 16
) (
  input  logic [LEVELS-1:0]         bits,
  output logic                      found,
  output logic [$clog2(LEVELS)-1:0] idx
);

  localparam int IDX_W = $clog2(LEVELS);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (bits[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/prqs_ready_queues.sv
// Per-level linked ready queues, ready marks and the current task.
// Computes the response of one request and updates all state on fire.
// Depends on prqs_pkg and prqs_prio_enc.
`default_nettype none

module prqs_ready_queues import prqs_pkg::*; #(
  parameter int PRIO_LEVELS = 16,
  parameter int MAX_TASKS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  req_t              req,
  input  logic [TASK_W-1:0] idle_task,
  output rsp_t              rsp
);

  localparam int TIDX_W = $clog2(MAX_TASKS);
  localparam int LIDX_W = $clog2(PRIO_LEVELS);

  logic [TASK_W-1:0]      next_link_r [MAX_TASKS];
  logic [TASK_W-1:0]      head_r [PRIO_LEVELS];
  logic [TASK_W-1:0]      tail_r [PRIO_LEVELS];
  logic [MAX_TASKS-1:0]   is_last_r;
  logic [MAX_TASKS-1:0]   ready_mark_r, ready_mark_nxt;
  logic [PRIO_LEVELS-1:0] active_r, active_nxt;
  logic [TASK_W-1:0]      cur_task_r, cur_task_nxt;
  logic [PRIO_W-1:0]      cur_prio_r, cur_prio_nxt;

  function automatic logic [TIDX_W-1:0] tidx(input logic [TASK_W-1:0] t);
    logic [TIDX_W+TASK_W-1:0] e;
    e = {{TIDX_W{1'b0}}, t};
    return e[TIDX_W-1:0];
  endfunction

  function automatic logic t_in_range(input logic [TASK_W-1:0] t);
    logic [TIDX_W+TASK_W-1:0] e;
    e = {{TIDX_W{1'b0}}, t};
    return e < (TIDX_W+TASK_W)'(MAX_TASKS);
  endfunction

  function automatic logic [LIDX_W-1:0] lsat(input logic [PRIO_W-1:0] p);
    logic [LIDX_W+PRIO_W-1:0] e;
    e = {{LIDX_W{1'b0}}, p};
    return (e >= (LIDX_W+PRIO_W)'(PRIO_LEVELS)) ? LIDX_W'(PRIO_LEVELS - 1)
                                                : e[LIDX_W-1:0];
  endfunction

  function automatic logic [PRIO_W-1:0] lvl2prio(input logic [LIDX_W-1:0] l);
    logic [LIDX_W+PRIO_W-1:0] e;
    e = {{PRIO_W{1'b0}}, l};
    return e[PRIO_W-1:0];
  endfunction

  logic                   is_sw, is_mr, same, chk_ok;
  logic                   enq_en, rq_en, app_en, app_act, rq_hit;
  logic                   pk_found, pick_en, single;
  logic [LIDX_W-1:0]      mr_lvl, rl, app_lvl, pk_lvl;
  logic [TASK_W-1:0]      app_task, app_tail, hv, next_val;
  logic [TIDX_W-1:0]      hv_idx;
  logic [PRIO_LEVELS-1:0] active_app;

  assign is_sw    = (req.command == CMD_SWITCH);
  assign is_mr    = (req.command == CMD_MAKE_READY);
  assign mr_lvl   = lsat(req.prio);
  assign rl       = lsat(cur_prio_r);
  assign same     = (req.task_id == cur_task_r);
  assign app_task = is_sw ? cur_task_r : req.task_id;
  assign app_lvl  = is_sw ? rl : mr_lvl;
  assign chk_ok   = t_in_range(app_task) && !ready_mark_r[tidx(app_task)];
  assign enq_en   = is_mr && !same && chk_ok;
  assign rq_en    = is_sw && req.requeue_current && chk_ok;
  assign app_en   = enq_en || rq_en;
  assign app_act  = active_r[app_lvl];
  assign app_tail = tail_r[app_lvl];

  assign active_app = active_r | (rq_en ? (PRIO_LEVELS'(1) << rl) : '0);

  prqs_prio_enc #(
    .LEVELS (PRIO_LEVELS)
  ) u_prio_enc (
    .bits  (active_app),
    .found (pk_found),
    .idx   (pk_lvl)
  );

  assign pick_en  = is_sw && pk_found;
  assign rq_hit   = rq_en && (pk_lvl == rl);
  assign hv       = (rq_hit && !active_r[rl]) ? cur_task_r : head_r[pk_lvl];
  assign hv_idx   = tidx(hv);
  assign single   = rq_hit ? !active_r[rl] : is_last_r[hv_idx];
  assign next_val = (rq_hit && active_r[rl] && is_last_r[hv_idx]) ? cur_task_r
                                                                   : next_link_r[hv_idx];

  always_comb begin
    active_nxt     = active_r;
    ready_mark_nxt = ready_mark_r;
    if (app_en) begin
      active_nxt[app_lvl]            = 1'b1;
      ready_mark_nxt[tidx(app_task)] = 1'b1;
    end
    if (pick_en) begin
      ready_mark_nxt[hv_idx] = 1'b0;
      if (single) begin
        active_nxt[pk_lvl] = 1'b0;
      end
    end
  end

  always_comb begin
    cur_task_nxt = cur_task_r;
    cur_prio_nxt = cur_prio_r;
    if (is_sw) begin
      if (pk_found) begin
        cur_task_nxt = hv;
        cur_prio_nxt = lvl2prio(pk_lvl);
      end else begin
        cur_task_nxt = idle_task;
        cur_prio_nxt = '0;
      end
    end
  end

  always_comb begin
    rsp.picked_task = cur_task_nxt;
    rsp.picked_prio = cur_prio_nxt;
    rsp.idle_chosen = is_sw && !pk_found;
    rsp.preempt     = is_mr && (same || (enq_en && (mr_lvl >= rl)));
    rsp.status      = (is_mr && !same && !chk_ok) ? STATUS_IGNORED : STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      ready_mark_r <= '0;
      cur_task_r   <= IDLE_RESET;
      cur_prio_r   <= '0;
    end else if (fire) begin
      active_r     <= active_nxt;
      ready_mark_r <= ready_mark_nxt;
      cur_task_r   <= cur_task_nxt;
      cur_prio_r   <= cur_prio_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (app_en) begin
        if (app_act) begin
          next_link_r[tidx(app_tail)] <= app_task;
          is_last_r[tidx(app_tail)]   <= 1'b0;
        end else begin
          head_r[app_lvl] <= app_task;
        end
        tail_r[app_lvl]           <= app_task;
        is_last_r[tidx(app_task)] <= 1'b1;
      end
      if (pick_en && !single) begin
        head_r[pk_lvl] <= next_val;
      end
    end
  end

  a_pick_unmarks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && pick_en |=> !ready_mark_r[$past(hv_idx)])
    else $error("picked task still marked ready");

  a_idle_only_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fire && rsp.idle_chosen |-> (active_r == '0) && !rq_en)
    else $error("idle chosen with a non-empty queue");

  a_ignored_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (rsp.status == STATUS_IGNORED) |=> $stable(active_r) && $stable(ready_mark_r))
    else $error("ignored insert changed the queues");

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for the priority ready-queue scheduler: directed and random requests
// checked against a scoreboard that models the per-level task queues.
// Depends on prqs_pkg, prqs_if and priority_ready_queue_scheduler_unit.
`timescale 1ns / 100ps

module tb import prqs_pkg::*;;

  localparam int NUM_LEVELS  = 16;
  localparam int NUM_TASKS   = 32;
  localparam int CYCLE_LIMIT = 400000;

  class pick_scoreboard;
    logic [TASK_W-1:0] link [NUM_TASKS];
    logic [TASK_W-1:0] head [NUM_LEVELS];
    logic [TASK_W-1:0] tail [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] active;
    bit                marked [NUM_TASKS];
    logic [TASK_W-1:0] cur_task;
    logic [PRIO_W-1:0] cur_prio;
    logic [TASK_W-1:0] idle_id;
    rsp_t              picks_due [$];
    int                errors;

    function new();
      foreach (link[i]) begin
        link[i] = '0;
        marked[i] = 1'b0;
      end
      foreach (head[i]) begin
        head[i] = '0;
        tail[i] = '0;
      end
      active = '0;
      idle_id = IDLE_RESET;
      cur_task = IDLE_RESET;
      cur_prio = '0;
      errors = 0;
    endfunction

    function void set_idle(logic [TASK_W-1:0] id);
      idle_id = id;
    endfunction

    function int pending();
      return picks_due.size();
    endfunction

    function bit enqueue(logic [TASK_W-1:0] t, logic [PRIO_W-1:0] lvl);
      if (marked[t]) return 1'b0;
      if (active[lvl]) begin
        link[tail[lvl]] = t;
      end else begin
        head[lvl] = t;
        active[lvl] = 1'b1;
      end
      tail[lvl] = t;
      marked[t] = 1'b1;
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      rsp_t              e;
      int                lvl;
      logic [TASK_W-1:0] pick;
      e = '0;
      if (r.command == CMD_MAKE_READY) begin
        if (r.task_id == cur_task) begin
          e.preempt = 1'b1;
        end else if (enqueue(r.task_id, r.prio)) begin
          e.preempt = (r.prio >= cur_prio);
        end else begin
          e.status = STATUS_IGNORED;
        end
      end else begin
        if (r.requeue_current) void'(enqueue(cur_task, cur_prio));
        lvl = -1;
        for (int p = 0; p < NUM_LEVELS; p++) if (active[p]) lvl = p;
        if (lvl < 0) begin
          cur_task = idle_id;
          cur_prio = '0;
          e.idle_chosen = 1'b1;
        end else begin
          pick = head[lvl];
          if (pick == tail[lvl]) active[lvl] = 1'b0;
          else head[lvl] = link[pick];
          marked[pick] = 1'b0;
          cur_task = pick;
          cur_prio = PRIO_W'(lvl);
        end
      end
      e.picked_task = cur_task;
      e.picked_prio = cur_prio;
      picks_due.push_back(e);
    endfunction

    task report_mismatch(string msg);
      $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    task check_response(rsp_t got);
      rsp_t e;
      if (picks_due.size() == 0) begin
        report_mismatch("response with no request outstanding");
        return;
      end
      e = picks_due.pop_front();
      if (got.picked_task !== e.picked_task)
        report_mismatch($sformatf("picked_task %0d, expected %0d", got.picked_task,
                                  e.picked_task));
      if (got.picked_prio !== e.picked_prio)
        report_mismatch($sformatf("picked_prio %0d, expected %0d", got.picked_prio,
                                  e.picked_prio));
      if (got.idle_chosen !== e.idle_chosen)
        report_mismatch($sformatf("idle_chosen %b, expected %b", got.idle_chosen,
                                  e.idle_chosen));
      if (got.preempt !== e.preempt)
        report_mismatch($sformatf("preempt %b, expected %b", got.preempt, e.preempt));
      if (got.status !== e.status)
        report_mismatch($sformatf("status %b, expected %b", got.status, e.status));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  bit   tx_idle = 1'b0;
  bit   rx_idle = 1'b0;
  int   hold_len = 0;
  pick_scoreboard sb;

  prqs_in_if  in_chan ();
  prqs_out_if out_chan ();
  prqs_cfg_if cfg_chan ();

  priority_ready_queue_scheduler_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int   stall_left;
    rsp_t got;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got.picked_task = out_chan.picked_task;
        got.picked_prio = out_chan.picked_prio;
        got.idle_chosen = out_chan.idle_chosen;
        got.preempt     = out_chan.preempt;
        got.status      = out_chan.status;
        sb.check_response(got);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_len > 0) begin
        stall_left = hold_len;
        hold_len = 0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
      end
      out_chan.ready <= rst_n && (stall_left == 0);
    end
  end

  function automatic int next_gap();
    int r;
    if (!tx_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic req_t mk_req(cmd_t cmd, int t, int p, bit rq);
    req_t r;
    r.command = cmd;
    r.task_id = TASK_W'(t);
    r.prio = PRIO_W'(p);
    r.requeue_current = rq;
    return r;
  endfunction

  function automatic req_t random_request(int make_pct, int task_hi, int prio_hi);
    return mk_req(($urandom_range(0, 99) < make_pct) ? CMD_MAKE_READY : CMD_SWITCH,
                  $urandom_range(0, task_hi), $urandom_range(0, prio_hi),
                  $urandom_range(0, 1));
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    in_chan.valid <= 1'b1;
    in_chan.command <= r.command;
    in_chan.task_id <= r.task_id;
    in_chan.prio <= r.prio;
    in_chan.requeue_current <= r.requeue_current;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_request(r);
    gap = next_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_idle(input logic [TASK_W-1:0] id);
    wait_drained();
    cfg_chan.valid <= 1'b1;
    cfg_chan.idle_task <= id;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    sb.set_idle(id);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic run_random(input int n, input int make_pct, input int task_hi,
                            input int prio_hi);
    repeat (n) send_req(random_request(make_pct, task_hi, prio_hi));
  endtask

  initial begin
    req_t directed [$];
    sb = new();
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.command <= CMD_MAKE_READY;
    in_chan.task_id <= '0;
    in_chan.prio <= '0;
    in_chan.requeue_current <= 1'b0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.idle_task <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk_req(CMD_SWITCH, 0, 0, 0));
    directed.push_back(mk_req(CMD_MAKE_READY, 0, 5, 0));
    directed.push_back(mk_req(CMD_MAKE_READY, 31, 15, 0));
    directed.push_back(mk_req(CMD_MAKE_READY, 31, 3, 1));
    directed.push_back(mk_req(CMD_MAKE_READY, 1, 0, 0));
    directed.push_back(mk_req(CMD_MAKE_READY, 2, 0, 0));
    directed.push_back(mk_req(CMD_SWITCH, 17, 9, 1));
    directed.push_back(mk_req(CMD_MAKE_READY, 3, 14, 0));
    directed.push_back(mk_req(CMD_MAKE_READY, 4, 15, 0));
    directed.push_back(mk_req(CMD_MAKE_READY, 31, 0, 0));
    directed.push_back(mk_req(CMD_SWITCH, 0, 0, 1));
    directed.push_back(mk_req(CMD_SWITCH, 31, 15, 0));
    directed.push_back(mk_req(CMD_SWITCH, 0, 0, 0));
    directed.push_back(mk_req(CMD_SWITCH, 0, 0, 0));
    directed.push_back(mk_req(CMD_SWITCH, 0, 0, 0));
    directed.push_back(mk_req(CMD_SWITCH, 0, 0, 0));
    directed.push_back(mk_req(CMD_SWITCH, 0, 0, 0));
    directed.push_back(mk_req(CMD_MAKE_READY, 21, 10, 1));
    directed.push_back(mk_req(CMD_SWITCH, 31, 15, 1));
    directed.push_back(mk_req(CMD_SWITCH, 0, 0, 0));
    directed.push_back(mk_req(CMD_SWITCH, 0, 0, 1));
    foreach (directed[i]) send_req(directed[i]);

    write_idle(5'd31);
    hold_len = 150;
    rx_idle = 1'b1;
    run_random(200, 60, 31, 15);
    tx_idle = 1'b1;
    run_random(300, 60, 31, 15);

    write_idle(5'd0);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(400, 55, 7, 3);

    write_idle(TASK_W'($urandom_range(0, 31)));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random(400, 65, 31, 15);

    write_idle(TASK_W'($urandom_range(0, 31)));
    run_random(380, 45, 15, 7);

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### priority_ready_queue_scheduler_unit.f
hdl/prqs_pkg.sv
hdl/prqs_if.sv
hdl/prqs_prio_enc.sv
hdl/prqs_ready_queues.sv
hdl/priority_ready_queue_scheduler_unit.sv
tb/tb.sv
